// File: rtl/client_sequence_tracker_macros.svh
// assertion macros shared by the client sequence tracker rtl
`ifndef CLIENT_SEQUENCE_TRACKER_MACROS_SVH
`define CLIENT_SEQUENCE_TRACKER_MACROS_SVH

// same-cycle implication, checked out of reset
`define CST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cst_pkg.sv
// shared types and constants of the client sequence tracker
package cst_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 16;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned PORT_W    = 16;
    localparam int unsigned SEQ_W     = 32;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TIMEOUT_W = 17;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(120);

    // one slot of the client table
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [PORT_W-1:0] port;
        logic [SEQ_W-1:0]  highest;
        logic [TIME_W-1:0] last_update;
    } t_entry;

endpackage

// File: rtl/client_sequence_tracker.sv
// client sequence tracker: table search, insert and per-client sequence check
`include "client_sequence_tracker_macros.svh"

// Tracks the highest sequence number seen from each client (address and
// port) in a table of TABLE_ENTRIES slots held in a memory with one write
// and one registered read port. After a request beat is accepted, a
// sequencer reads the filled slots in order, one per cycle, and one
// address/port comparator checks each registered read against the request.
// The walk ends on a hit or after the last filled slot, then the update
// state writes the slot and loads the result register. The request side
// stalls from acceptance until the sequencer is back in idle, so a new
// request beat is taken only after the last one is finished; a full
// result register that is not taken holds the sequencer in its update
// state. A finished result waits in the output register, and a new
// request is taken while it waits. On a miss the client is appended
// while a slot is free, else table_full is flagged. On a hit, an entry
// idle for timeout_seconds or more (wrapping 32-bit time difference) is
// restarted; otherwise a lower sequence is flagged out of order and a
// higher one becomes the new highest. The table needs no clearing after
// reset: only slots below the fill count are ever read. timeout_seconds
// is written through the config channel, always ready; the user must
// write it only while the block is idle, the block does not enforce it.
module client_sequence_tracker #(
    parameter int unsigned TABLE_ENTRIES = cst_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cst_pkg::TIMEOUT_W-1:0]  i_cfg_timeout_seconds,

    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [cst_pkg::ADDR_W-1:0]     i_client_address,
    input  logic [cst_pkg::PORT_W-1:0]     i_client_port,
    input  logic [cst_pkg::SEQ_W-1:0]      i_sequence_req,
    input  logic [cst_pkg::TIME_W-1:0]     i_now_seconds,

    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_out_of_order,
    output logic [cst_pkg::SEQ_W-1:0]      o_reported_highest,
    output logic                           o_client_inserted,
    output logic                           o_expired_reset,
    output logic                           o_table_full
);

    // fill count holds 0..TABLE_ENTRIES, slot index only 0..TABLE_ENTRIES-1
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    // sequencer codes
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    // control state
    logic [1:0]                      r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [CW-1:0]                   r_rd_idx, n_rd_idx;
    logic                            r_dv, n_dv;
    logic [CW-1:0]                   r_dv_idx, n_dv_idx;
    logic [CW-1:0]                   r_slot, n_slot;
    logic                            r_hit, n_hit;
    logic [cst_pkg::TIMEOUT_W-1:0]   r_timeout;
    logic                            r_o_valid, n_o_valid;

    // latched request
    logic [cst_pkg::ADDR_W-1:0]      r_in_addr;
    logic [cst_pkg::PORT_W-1:0]      r_in_port;
    logic [cst_pkg::SEQ_W-1:0]       r_in_seq;
    logic [cst_pkg::TIME_W-1:0]      r_in_now;

    // result register
    logic                            r_o_ooo;
    logic [cst_pkg::SEQ_W-1:0]       r_o_highest;
    logic                            r_o_new;
    logic                            r_o_expired;
    logic                            r_o_full;

    // client table and its registered read
    cst_pkg::t_entry                 r_mem [TABLE_ENTRIES];
    cst_pkg::t_entry                 r_rd;

    // handshakes
    logic in_take;
    logic out_take;
    logic out_free;

    // search and decision
    logic                            match;
    logic                            rd_en;
    logic                            finish;
    logic [cst_pkg::TIME_W-1:0]      elapsed;
    logic                            dec_expired;
    logic                            dec_ooo;
    logic                            dec_update;
    logic                            dec_full;
    logic                            dec_insert;
    logic                            mem_we;
    cst_pkg::t_entry                 mem_wdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = r_o_valid && !i_out_stall;
    // result register can take a new result this cycle
    assign out_free    = !r_o_valid || !i_out_stall;

    // the one comparator, fed by the slot read last cycle
    assign match = r_dv && (r_rd.address == r_in_addr) && (r_rd.port == r_in_port);

    // keep walking while filled slots remain and nothing matched yet
    assign rd_en = (r_state == S_SEARCH) && !match && (r_rd_idx < r_count);

    // decision on the matched slot, or on the miss
    always_comb begin
        elapsed     = r_in_now - r_rd.last_update;
        dec_expired = r_hit && (elapsed >= cst_pkg::TIME_W'(r_timeout));
        dec_ooo     = r_hit && !dec_expired && (r_in_seq < r_rd.highest);
        dec_update  = r_hit && (dec_expired || (r_in_seq > r_rd.highest));
        dec_full    = !r_hit && (r_count == FULL_COUNT);
        dec_insert  = !r_hit && !dec_full;
    end

    assign finish    = (r_state == S_UPDATE) && out_free;
    assign mem_we    = finish && (dec_update || dec_insert);
    assign mem_wdata = '{address:     r_in_addr,
                         port:        r_in_port,
                         highest:     r_in_seq,
                         last_update: r_in_now};

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_dv      = 1'b0;
        n_dv_idx  = r_rd_idx;
        n_slot    = r_slot;
        n_hit     = r_hit;
        n_o_valid = r_o_valid;

        if (out_take) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state  = S_SEARCH;
                    n_rd_idx = '0;
                end
            end
            S_SEARCH: begin
                priority if (match) begin
                    n_state = S_UPDATE;
                    n_hit   = 1'b1;
                    n_slot  = r_dv_idx;
                end else if (rd_en) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_dv     = 1'b1;
                end else begin
                    // every filled slot compared, no match
                    n_state = S_UPDATE;
                    n_hit   = 1'b0;
                    n_slot  = r_count;
                end
            end
            S_UPDATE: begin
                if (finish) begin
                    n_state   = S_IDLE;
                    n_o_valid = 1'b1;
                    if (dec_insert) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_dv      <= 1'b0;
            r_dv_idx  <= '0;
            r_slot    <= '0;
            r_hit     <= 1'b0;
            r_timeout <= cst_pkg::TIMEOUT_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_idx  <= n_rd_idx;
            r_dv      <= n_dv;
            r_dv_idx  <= n_dv_idx;
            r_slot    <= n_slot;
            r_hit     <= n_hit;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_timeout_seconds;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_addr <= i_client_address;
            r_in_port <= i_client_port;
            r_in_seq  <= i_sequence_req;
            r_in_now  <= i_now_seconds;
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_o_ooo     <= dec_ooo;
            r_o_highest <= r_hit ? r_rd.highest : '0;
            r_o_new     <= dec_insert;
            r_o_expired <= dec_expired;
            r_o_full    <= dec_full;
        end
    end

    // client table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot[IW-1:0]] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd <= r_mem[r_rd_idx[IW-1:0]];
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_out_of_order     = r_o_ooo;
    assign o_reported_highest = r_o_highest;
    assign o_client_inserted  = r_o_new;
    assign o_expired_reset    = r_o_expired;
    assign o_table_full       = r_o_full;

    // checks
    `CST_ASSERT_NOW(a_count_bound, 1'b1, r_count <= FULL_COUNT,
        "fill count beyond table size")
    `CST_ASSERT_NOW(a_flags_exclusive, r_o_valid,
        $onehot0({r_o_ooo, r_o_new, r_o_expired, r_o_full}),
        "more than one result flag set")
    `CST_ASSERT_NOW(a_full_result, r_o_valid && r_o_full,
        (r_o_highest == '0) && (r_count == FULL_COUNT),
        "table full result with nonzero highest or free slot")
    `CST_ASSERT_NEXT(a_accept_starts_search, in_take, r_state == S_SEARCH,
        "accepted request did not start the table walk")
    `CST_ASSERT_NEXT(a_insert_grows, finish && dec_insert,
        (r_count == $past(r_count) + 1'b1) && r_o_new,
        "insert did not grow the fill count")

endmodule
